// File: rtl/periodic_lattice_index_unit_macros.svh
// Assertion macros shared by the lattice index unit RTL.
`ifndef PERIODIC_LATTICE_INDEX_UNIT_MACROS_SVH
`define PERIODIC_LATTICE_INDEX_UNIT_MACROS_SVH

// Plain concurrent check on a clock with active-low reset.
`define PLIM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after the condition.
`define PLIM_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/plim_pkg.sv
// Types, constants and helpers of the lattice index unit.
`timescale 1ns / 1ps
package plim_pkg;

  localparam int unsigned IDX_W     = 40;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned SIDE_W    = 11;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned DIMS_W    = 3;
  localparam int unsigned DIM_SLOTS = 4;
  localparam int unsigned STEP_BITS = 4;
  localparam int unsigned DIV_SUBS  = IDX_W / STEP_BITS;
  localparam int unsigned CFG_AW    = 5;
  localparam int unsigned CFG_DW    = 32;

  localparam int unsigned MAX_DIMENSIONS_DEF = 4;
  localparam int unsigned SIDE_LIMIT_DEF     = 1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_TO_COORDS = 3'd0,
    ACT_TO_INDEX  = 3'd1,
    ACT_RELATIVE  = 3'd2,
    ACT_MIN_IMAGE = 3'd3,
    ACT_INVERSE   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    REG_DIMENSIONS = 3'd0,
    REG_SIDE_0     = 3'd1,
    REG_SIDE_1     = 3'd2,
    REG_SIDE_2     = 3'd3,
    REG_SIDE_3     = 3'd4
  } reg_e;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [IDX_W-1:0]   site_index;
    logic [COORD_W-1:0] coord_a_0;
    logic [COORD_W-1:0] coord_a_1;
    logic [COORD_W-1:0] coord_a_2;
    logic [COORD_W-1:0] coord_a_3;
    logic [COORD_W-1:0] coord_b_0;
    logic [COORD_W-1:0] coord_b_1;
    logic [COORD_W-1:0] coord_b_2;
    logic [COORD_W-1:0] coord_b_3;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   site_index_result;
    logic [COORD_W-1:0] coord_out_0;
    logic [COORD_W-1:0] coord_out_1;
    logic [COORD_W-1:0] coord_out_2;
    logic [COORD_W-1:0] coord_out_3;
    logic               range_error;
  } rsp_t;

  // Item state while it walks the divider cells.
  typedef struct packed {
    logic [ACT_W-1:0]                    action;
    logic [IDX_W-1:0]                    lane_a;
    logic [IDX_W-1:0]                    lane_b;
    logic [SIDE_W-1:0]                   rem_a;
    logic [SIDE_W-1:0]                   rem_b;
    logic [DIM_SLOTS-1:0][COORD_W-1:0]   coord_a;
    logic [DIM_SLOTS-1:0][COORD_W-1:0]   coord_b;
    logic [DIM_SLOTS-1:0][SIDE_W-1:0]    res_a;
    logic [DIM_SLOTS-1:0][SIDE_W-1:0]    res_b;
    logic                                err;
  } div_item_t;

  // Item state while it walks the Horner pack cells.
  typedef struct packed {
    logic [IDX_W-1:0]                    acc;
    logic [DIM_SLOTS-1:0][SIDE_W-1:0]    term;
    logic [DIM_SLOTS-1:0][COORD_W-1:0]   coord;
    logic                                err;
  } pack_item_t;

  function automatic logic wraps_a(logic [ACT_W-1:0] act);
    return act inside {ACT_TO_INDEX, ACT_RELATIVE, ACT_MIN_IMAGE};
  endfunction

  function automatic logic uses_b(logic [ACT_W-1:0] act);
    return act inside {ACT_RELATIVE, ACT_MIN_IMAGE};
  endfunction

  function automatic logic splits_index(logic [ACT_W-1:0] act);
    return act inside {ACT_TO_COORDS, ACT_INVERSE};
  endfunction

endpackage

// File: rtl/plim_stream_if.sv
// Valid/ready stream channel carrying one payload type.
`timescale 1ns / 1ps
interface plim_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/plim_div_cell.sv
// Divider step cell: four restoring quotient bits on both coordinate lanes.
`timescale 1ns / 1ps
module plim_div_cell #(
  parameter int unsigned DIM   = 0,
  parameter bit          FIRST = 1'b0,
  parameter bit          LAST  = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  plim_pkg::div_item_t           item_i,
  input  logic [plim_pkg::SIDE_W-1:0]   side_i,
  input  logic                          used_i,
  output logic                          valid_o,
  output plim_pkg::div_item_t           item_o
);
  import plim_pkg::*;

  div_item_t         item_d, item_q;
  logic              valid_q;
  logic [SIDE_W:0]   trial_a, trial_b;

  always_comb begin
    item_d  = item_i;
    trial_a = '0;
    trial_b = '0;
    if (FIRST) begin
      item_d.rem_a  = '0;
      item_d.rem_b  = '0;
      item_d.lane_b = IDX_W'(item_i.coord_b[DIM]);
      // coordinate actions restart lane a from this dimension's coordinate
      if (!splits_index(item_i.action)) begin
        item_d.lane_a = IDX_W'(item_i.coord_a[DIM]);
      end
    end
    for (int s = 0; s < STEP_BITS; s++) begin
      trial_a = {item_d.rem_a, item_d.lane_a[IDX_W-1]};
      trial_b = {item_d.rem_b, item_d.lane_b[IDX_W-1]};
      item_d.lane_a = {item_d.lane_a[IDX_W-2:0], 1'b0};
      item_d.lane_b = {item_d.lane_b[IDX_W-2:0], 1'b0};
      if (trial_a >= {1'b0, side_i}) begin
        trial_a = trial_a - {1'b0, side_i};
        item_d.lane_a[0] = 1'b1;
      end
      if (trial_b >= {1'b0, side_i}) begin
        trial_b = trial_b - {1'b0, side_i};
        item_d.lane_b[0] = 1'b1;
      end
      item_d.rem_a = trial_a[SIDE_W-1:0];
      item_d.rem_b = trial_b[SIDE_W-1:0];
    end
    if (LAST) begin
      item_d.res_a[DIM] = item_d.rem_a;
      item_d.res_b[DIM] = item_d.rem_b;
      // a nonzero quotient means the coordinate was outside its side
      if (used_i && wraps_a(item_d.action) && (item_d.lane_a != '0)) begin
        item_d.err = 1'b1;
      end
      if (used_i && uses_b(item_d.action) && (item_d.lane_b != '0)) begin
        item_d.err = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/plim_fold_stage.sv
// Fold stage: per-dimension differences, mirror terms and range flag.
`timescale 1ns / 1ps
module plim_fold_stage (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              adv_i,
  input  logic                                              valid_i,
  input  plim_pkg::div_item_t                               item_i,
  input  logic [plim_pkg::DIM_SLOTS-1:0][plim_pkg::SIDE_W-1:0] side_i,
  output logic                                              valid_o,
  output plim_pkg::pack_item_t                              item_o
);
  import plim_pkg::*;

  pack_item_t item_d, item_q;
  logic       valid_q;

  always_comb begin
    logic [SIDE_W-1:0] x, y, n, d, e, mi, m;
    logic [SIDE_W:0]   d_wide;
    item_d     = '0;
    item_d.err = item_i.err |
                 (splits_index(item_i.action) && (item_i.lane_a != '0));
    for (int k = 0; k < DIM_SLOTS; k++) begin
      x = item_i.res_a[k];
      y = item_i.res_b[k];
      n = side_i[k];
      if (y >= x) begin
        d_wide = {1'b0, y} - {1'b0, x};
      end else begin
        d_wide = {1'b0, y} + {1'b0, n} - {1'b0, x};
      end
      d  = d_wide[SIDE_W-1:0];
      e  = (d == '0) ? '0 : n - d;
      mi = (e < d) ? e : d;
      m  = (x == '0) ? '0 : n - x;
      case (item_i.action)
        ACT_TO_COORDS: item_d.coord[k] = x[COORD_W-1:0];
        ACT_TO_INDEX:  item_d.term[k]  = x;
        ACT_RELATIVE:  item_d.coord[k] = d[COORD_W-1:0];
        ACT_MIN_IMAGE: item_d.coord[k] = mi[COORD_W-1:0];
        ACT_INVERSE:   item_d.term[k]  = m;
        default:       item_d.coord[k] = '0;
      endcase
    end
    // unknown actions report nothing at all
    if (item_i.action > ACT_INVERSE) begin
      item_d.err = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/plim_pack_cell.sv
// Horner pack cell: acc = acc * side + term for one dimension.
`timescale 1ns / 1ps
module plim_pack_cell #(
  parameter int unsigned DIM = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  plim_pkg::pack_item_t          item_i,
  input  logic [plim_pkg::SIDE_W-1:0]   side_i,
  output logic                          valid_o,
  output plim_pkg::pack_item_t          item_o
);
  import plim_pkg::*;

  pack_item_t                item_d, item_q;
  logic                      valid_q;
  logic [IDX_W+SIDE_W-1:0]   prod;

  always_comb begin
    prod       = (IDX_W + SIDE_W)'(item_i.acc) * (IDX_W + SIDE_W)'(side_i);
    item_d     = item_i;
    item_d.acc = prod[IDX_W-1:0] + IDX_W'(item_i.term[DIM]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/periodic_lattice_index_unit.sv
// Throughput: one beat per cycle unless the response side stalls; each divider cell
// retires four quotient bits, ten cells per dimension, then one fold stage and one
// multiply per dimension. Stalls fill bubbles stage by stage, so a beat enters
// while a result waits as long as some stage is empty.
// Reset clears all stage valids and loads dimensions = 1 and every side = 1.
`timescale 1ns / 1ps
`include "periodic_lattice_index_unit_macros.svh"
module periodic_lattice_index_unit #(
  parameter int unsigned MAX_DIMENSIONS = plim_pkg::MAX_DIMENSIONS_DEF,
  parameter int unsigned SIDE_LIMIT     = plim_pkg::SIDE_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plim_stream_if.sink                   req_i,
  plim_stream_if.source                 rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plim_pkg::CFG_AW-1:0]   paddr,
  input  logic [plim_pkg::CFG_DW-1:0]   pwdata,
  output logic [plim_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import plim_pkg::*;

  localparam int unsigned NDIV  = MAX_DIMENSIONS * DIV_SUBS;
  localparam int unsigned NST   = NDIV + 1 + MAX_DIMENSIONS;
  localparam int unsigned SMAX  = (1 << SIDE_W) - 1;
  localparam int unsigned LIM_I = (SIDE_LIMIT > SMAX) ? SMAX : SIDE_LIMIT;
  localparam logic [SIDE_W-1:0] LIM = LIM_I[SIDE_W-1:0];

  logic [DIMS_W-1:0]                 dims_q;
  logic [DIM_SLOTS-1:0][SIDE_W-1:0]  side_q;
  logic [DIMS_W-1:0]                 dcount;
  logic [DIM_SLOTS-1:0]              used;
  logic [DIM_SLOTS-1:0][SIDE_W-1:0]  side_eff;

  logic [NST-1:0]  v;
  logic [NST-1:0]  adv;
  div_item_t       div_init;
  div_item_t       div_q [NDIV];
  pack_item_t      pk [MAX_DIMENSIONS+1];
  logic            cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DIMS_W'(1);
      for (int k = 0; k < DIM_SLOTS; k++) side_q[k] <= SIDE_W'(1);
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1:2])
        REG_DIMENSIONS: dims_q    <= pwdata[DIMS_W-1:0];
        REG_SIDE_0:     side_q[0] <= pwdata[SIDE_W-1:0];
        REG_SIDE_1:     side_q[1] <= pwdata[SIDE_W-1:0];
        REG_SIDE_2:     side_q[2] <= pwdata[SIDE_W-1:0];
        REG_SIDE_3:     side_q[3] <= pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_DIMENSIONS: prdata = CFG_DW'(dims_q);
      REG_SIDE_0:     prdata = CFG_DW'(side_q[0]);
      REG_SIDE_1:     prdata = CFG_DW'(side_q[1]);
      REG_SIDE_2:     prdata = CFG_DW'(side_q[2]);
      REG_SIDE_3:     prdata = CFG_DW'(side_q[3]);
      default:        prdata = '0;
    endcase
  end

  // effective lattice shape; unused dimensions act as side one
  always_comb begin
    if (dims_q == '0) begin
      dcount = DIMS_W'(1);
    end else if (dims_q > DIMS_W'(MAX_DIMENSIONS)) begin
      dcount = DIMS_W'(MAX_DIMENSIONS);
    end else begin
      dcount = dims_q;
    end
    for (int k = 0; k < DIM_SLOTS; k++) begin
      used[k] = DIMS_W'(k) < dcount;
      if (!used[k] || side_q[k] == '0) begin
        side_eff[k] = SIDE_W'(1);
      end else if (side_q[k] > LIM) begin
        side_eff[k] = LIM;
      end else begin
        side_eff[k] = side_q[k];
      end
    end
  end

  // advance a stage when it is empty or its successor moves
  always_comb begin
    adv[NST-1] = rsp_o.ready || !v[NST-1];
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign req_i.ready = adv[0];

  always_comb begin
    div_init            = '0;
    div_init.action     = req_i.data.action;
    div_init.lane_a     = req_i.data.site_index;
    div_init.coord_a[0] = req_i.data.coord_a_0;
    div_init.coord_a[1] = req_i.data.coord_a_1;
    div_init.coord_a[2] = req_i.data.coord_a_2;
    div_init.coord_a[3] = req_i.data.coord_a_3;
    div_init.coord_b[0] = req_i.data.coord_b_0;
    div_init.coord_b[1] = req_i.data.coord_b_1;
    div_init.coord_b[2] = req_i.data.coord_b_2;
    div_init.coord_b[3] = req_i.data.coord_b_3;
  end

  for (genvar k = 0; k < MAX_DIMENSIONS; k++) begin : g_dim
    for (genvar s = 0; s < DIV_SUBS; s++) begin : g_sub
      localparam int unsigned I = k * DIV_SUBS + s;
      if (I == 0) begin : g_head
        plim_div_cell #(.DIM(k), .FIRST(s == 0), .LAST(s == DIV_SUBS - 1)) u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .adv_i   (adv[I]),
          .valid_i (req_i.valid),
          .item_i  (div_init),
          .side_i  (side_eff[k]),
          .used_i  (used[k]),
          .valid_o (v[I]),
          .item_o  (div_q[I])
        );
      end else begin : g_body
        plim_div_cell #(.DIM(k), .FIRST(s == 0), .LAST(s == DIV_SUBS - 1)) u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .adv_i   (adv[I]),
          .valid_i (v[I-1]),
          .item_i  (div_q[I-1]),
          .side_i  (side_eff[k]),
          .used_i  (used[k]),
          .valid_o (v[I]),
          .item_o  (div_q[I])
        );
      end
    end
  end

  plim_fold_stage u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv[NDIV]),
    .valid_i (v[NDIV-1]),
    .item_i  (div_q[NDIV-1]),
    .side_i  (side_eff),
    .valid_o (v[NDIV]),
    .item_o  (pk[0])
  );

  // highest dimension first for Horner order
  for (genvar j = 0; j < MAX_DIMENSIONS; j++) begin : g_pack
    plim_pack_cell #(.DIM(MAX_DIMENSIONS - 1 - j)) u_pack (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv[NDIV+1+j]),
      .valid_i (v[NDIV+j]),
      .item_i  (pk[j]),
      .side_i  (side_eff[MAX_DIMENSIONS-1-j]),
      .valid_o (v[NDIV+1+j]),
      .item_o  (pk[j+1])
    );
  end

  assign rsp_o.valid                  = v[NST-1];
  assign rsp_o.data.site_index_result = pk[MAX_DIMENSIONS].acc;
  assign rsp_o.data.coord_out_0       = pk[MAX_DIMENSIONS].coord[0];
  assign rsp_o.data.coord_out_1       = pk[MAX_DIMENSIONS].coord[1];
  assign rsp_o.data.coord_out_2       = pk[MAX_DIMENSIONS].coord[2];
  assign rsp_o.data.coord_out_3       = pk[MAX_DIMENSIONS].coord[3];
  assign rsp_o.data.range_error       = pk[MAX_DIMENSIONS].err;

  `PLIM_ASSERT(a_accept_lands, clk_i, rst_ni, req_i.valid && req_i.ready |=> v[0], "accepted beat missing in first cell")
  `PLIM_ASSERT(a_div_tail_keeps, clk_i, rst_ni, v[NDIV-1] && !adv[NDIV-1] |=> v[NDIV-1], "stalled divider beat lost")
  `PLIM_ASSERT_HOLD(a_fold_holds, clk_i, rst_ni, v[NDIV] && !adv[NDIV], pk[0], "stalled fold beat changed")

endmodule
